// ===== rtl/core/hms_pkg.sv =====
// Shared types and constants for the millisecond time counter.
package hms_pkg;

   typedef enum logic [1:0] {
      OP_UP    = 2'd0,
      OP_DOWN  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_LOAD  = 2'd3
   } hms_op_type;

   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [5:0] SECOND_MAX = 6'd59;
   localparam logic [9:0] MILLI_MAX  = 10'd999;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [9:0] millis;
   } hms_time_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } hms_load_type;

   typedef struct packed {
      hms_time_type time_next;
      logic         day_rollover;
      logic         reached_zero;
   } hms_step_type;

endpackage

// ===== rtl/core/hms_step.sv =====
// Next-time logic: applies one operation to the current count.
module hms_step (
   input  hms_pkg::hms_op_type   operation,
   input  hms_pkg::hms_load_type load_value,
   input  hms_pkg::hms_time_type time_now,
   output hms_pkg::hms_step_type step_out
);
   import hms_pkg::*;

   logic milli_top;
   logic second_top;
   logic minute_top;
   logic hour_top;
   logic milli_zero;
   logic second_zero;
   logic minute_zero;
   logic hour_zero;

   // The count never leaves its range, so equality with the maximum marks a carry.
   assign milli_top   = (time_now.millis == MILLI_MAX);
   assign second_top  = (time_now.seconds == SECOND_MAX);
   assign minute_top  = (time_now.minutes == MINUTE_MAX);
   assign hour_top    = (time_now.hours == HOUR_MAX);
   assign milli_zero  = (time_now.millis == 10'd0);
   assign second_zero = (time_now.seconds == 6'd0);
   assign minute_zero = (time_now.minutes == 6'd0);
   assign hour_zero   = (time_now.hours == 5'd0);

   always_comb begin
      step_out.time_next    = time_now;
      step_out.day_rollover = 1'b0;
      step_out.reached_zero = 1'b0;
      unique case (operation)
         OP_UP: begin
            step_out.time_next.millis = milli_top ? 10'd0 : time_now.millis + 10'd1;
            if (milli_top) begin
               step_out.time_next.seconds = second_top ? 6'd0 : time_now.seconds + 6'd1;
               if (second_top) begin
                  step_out.time_next.minutes = minute_top ? 6'd0 : time_now.minutes + 6'd1;
                  if (minute_top) begin
                     step_out.time_next.hours = hour_top ? 5'd0 : time_now.hours + 5'd1;
                     step_out.day_rollover    = hour_top;
                  end
               end
            end
         end
         OP_DOWN: begin
            // A borrow reloads every lower digit with its maximum.
            if (!milli_zero) begin
               step_out.time_next.millis = time_now.millis - 10'd1;
            end else if (!second_zero) begin
               step_out.time_next.seconds = time_now.seconds - 6'd1;
               step_out.time_next.millis  = MILLI_MAX;
            end else if (!minute_zero) begin
               step_out.time_next.minutes = time_now.minutes - 6'd1;
               step_out.time_next.seconds = SECOND_MAX;
               step_out.time_next.millis  = MILLI_MAX;
            end else if (!hour_zero) begin
               step_out.time_next.hours   = time_now.hours - 5'd1;
               step_out.time_next.minutes = MINUTE_MAX;
               step_out.time_next.seconds = SECOND_MAX;
               step_out.time_next.millis  = MILLI_MAX;
            end else begin
               step_out.reached_zero = 1'b1;
            end
         end
         OP_CLEAR: begin
            step_out.time_next = '0;
         end
         OP_LOAD: begin
            step_out.time_next.hours   = (load_value.hours > HOUR_MAX) ?
                                         HOUR_MAX : load_value.hours;
            step_out.time_next.minutes = (load_value.minutes > MINUTE_MAX) ?
                                         MINUTE_MAX : load_value.minutes;
            step_out.time_next.seconds = (load_value.seconds > SECOND_MAX) ?
                                         SECOND_MAX : load_value.seconds;
            step_out.time_next.millis  = 10'd0;
         end
         default: begin
            step_out.time_next = time_now;
         end
      endcase
   end

endmodule

// ===== rtl/core/hms_millisecond_up_down_counter_top.sv =====
// Time-of-day counter (hours, minutes, seconds, milliseconds) counting up and down.
// Each accepted item (tick up, tick down, clear or load) returns one item holding the
// time after the operation, with a day rollover flag for an up tick that wraps to
// midnight and a reached-zero flag for a down tick at zero. An item goes from the input
// register through the next-time logic into the result register. A new item is taken
// every cycle, set by the single update of the count registers per cycle; a stalled
// result holds back the input only once both registers are full.
module hms_millisecond_up_down_counter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hms_pkg::hms_op_type req_operation,
   input  logic [4:0]          req_load_hours,
   input  logic [5:0]          req_load_minutes,
   input  logic [5:0]          req_load_seconds,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_hours,
   output logic [5:0]          rsp_minutes,
   output logic [5:0]          rsp_seconds,
   output logic [9:0]          rsp_millis,
   output logic                rsp_day_rollover,
   output logic                rsp_reached_zero
);
   import hms_pkg::*;

   logic         in_valid_ff;
   hms_op_type   in_op_ff;
   hms_load_type in_load_ff;
   hms_time_type count_ff;
   hms_time_type count_in;
   hms_step_type step_result;
   logic         out_valid_ff;
   logic         out_valid_in;
   hms_step_type out_data_ff;
   logic         out_free;
   logic         advance;
   logic         req_take;

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   hms_step u_step (
      .operation  (in_op_ff),
      .load_value (in_load_ff),
      .time_now   (count_ff),
      .step_out   (step_result)
   );

   assign count_in     = advance ? step_result.time_next : count_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff           <= req_operation;
         in_load_ff.hours   <= req_load_hours;
         in_load_ff.minutes <= req_load_minutes;
         in_load_ff.seconds <= req_load_seconds;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hours        = out_data_ff.time_next.hours;
   assign rsp_minutes      = out_data_ff.time_next.minutes;
   assign rsp_seconds      = out_data_ff.time_next.seconds;
   assign rsp_millis       = out_data_ff.time_next.millis;
   assign rsp_day_rollover = out_data_ff.day_rollover;
   assign rsp_reached_zero = out_data_ff.reached_zero;

   // A rollover or a down tick at zero always leaves the count at midnight.
   a_rollover_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_day_rollover) |-> (out_data_ff.time_next == '0))
      else $error("day rollover with nonzero time");

   a_floor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reached_zero) |-> (out_data_ff.time_next == '0))
      else $error("reached zero with nonzero time");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_day_rollover && rsp_reached_zero))
      else $error("both flags set");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      (count_ff.millis <= MILLI_MAX) && (count_ff.seconds <= SECOND_MAX) &&
      (count_ff.minutes <= MINUTE_MAX) && (count_ff.hours <= HOUR_MAX))
      else $error("count out of range");

   // The count only moves when an item passes into the result register.
   a_count_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("count changed without an item");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the up/down millisecond time-of-day counter.
`timescale 1ns / 1ps

module tb;
   import hms_pkg::*;

   localparam int ITEM_TARGET = 1050;
   localparam int DIRECTED_COUNT = 23;

   typedef struct packed {
      hms_op_type op;
      logic [4:0] ld_h;
      logic [5:0] ld_m;
      logic [5:0] ld_s;
      logic       checked;
      logic [4:0] w_h;
      logic [5:0] w_m;
      logic [5:0] w_s;
      logic [9:0] w_ms;
      logic       w_roll;
      logic       w_zero;
   } directed_row_type;

   // Rows marked checked carry their expected time; the rest use the predictor.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b1},
      '{OP_UP,    5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd1,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_LOAD,  5'd31, 6'd63, 6'd63, 1'b1, 5'd23, 6'd59, 6'd59, 10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd23, 6'd59, 6'd58, 10'd999, 1'b0, 1'b0},
      '{OP_UP,    5'd0,  6'd0,  6'd0,  1'b1, 5'd23, 6'd59, 6'd59, 10'd0,   1'b0, 1'b0},
      '{OP_LOAD,  5'd24, 6'd60, 6'd60, 1'b1, 5'd23, 6'd59, 6'd59, 10'd0,   1'b0, 1'b0},
      '{OP_LOAD,  5'd0,  6'd0,  6'd1,  1'b1, 5'd0,  6'd0,  6'd1,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd999, 1'b0, 1'b0},
      '{OP_UP,    5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd1,  10'd0,   1'b0, 1'b0},
      '{OP_LOAD,  5'd0,  6'd1,  6'd0,  1'b1, 5'd0,  6'd1,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd59, 10'd999, 1'b0, 1'b0},
      '{OP_UP,    5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd1,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_LOAD,  5'd1,  6'd0,  6'd0,  1'b1, 5'd1,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd59, 6'd59, 10'd999, 1'b0, 1'b0},
      '{OP_UP,    5'd0,  6'd0,  6'd0,  1'b1, 5'd1,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b0, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_CLEAR, 5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd0,  6'd0,  6'd0,  1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b1},
      '{OP_LOAD,  5'd10, 6'd20, 6'd30, 1'b0, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_UP,    5'd21, 6'd42, 6'd21, 1'b0, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_CLEAR, 5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b0},
      '{OP_DOWN,  5'd31, 6'd63, 6'd63, 1'b1, 5'd0,  6'd0,  6'd0,  10'd0,   1'b0, 1'b1}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   hms_op_type req_operation = OP_UP;
   logic [4:0] req_load_hours = '0;
   logic [5:0] req_load_minutes = '0;
   logic [5:0] req_load_seconds = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_hours;
   logic [5:0] rsp_minutes;
   logic [5:0] rsp_seconds;
   logic [9:0] rsp_millis;
   logic       rsp_day_rollover;
   logic       rsp_reached_zero;

   hms_time_type count_now = '0;
   hms_step_type expected_steps [$];
   hms_step_type oldest_step;
   int           fail_count = 0;
   int           items_sent = 0;
   int           stall_left = 0;
   bit           idle_on = 1'b0;

   hms_millisecond_up_down_counter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_load_hours   (req_load_hours),
      .req_load_minutes (req_load_minutes),
      .req_load_seconds (req_load_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hours        (rsp_hours),
      .rsp_minutes      (rsp_minutes),
      .rsp_seconds      (rsp_seconds),
      .rsp_millis       (rsp_millis),
      .rsp_day_rollover (rsp_day_rollover),
      .rsp_reached_zero (rsp_reached_zero)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("hms_millisecond_up_down_counter_top regression: fail");
      $finish;
   end

   // Time after one operation, with the wrap and at-zero flags.
   function automatic hms_step_type advance_time(input hms_time_type now,
                                                 input hms_op_type op,
                                                 input logic [4:0] ld_h,
                                                 input logic [5:0] ld_m,
                                                 input logic [5:0] ld_s);
      hms_step_type step;
      step = '0;
      step.time_next = now;
      case (op)
         OP_UP: begin
            if (now.millis != MILLI_MAX) begin
               step.time_next.millis = now.millis + 10'd1;
            end else begin
               step.time_next.millis = '0;
               if (now.seconds != SECOND_MAX) begin
                  step.time_next.seconds = now.seconds + 6'd1;
               end else begin
                  step.time_next.seconds = '0;
                  if (now.minutes != MINUTE_MAX) begin
                     step.time_next.minutes = now.minutes + 6'd1;
                  end else begin
                     step.time_next.minutes = '0;
                     if (now.hours != HOUR_MAX) begin
                        step.time_next.hours = now.hours + 5'd1;
                     end else begin
                        step.time_next.hours = '0;
                        step.day_rollover = 1'b1;
                     end
                  end
               end
            end
         end
         OP_DOWN: begin
            if (now.millis != '0) begin
               step.time_next.millis = now.millis - 10'd1;
            end else if (now.seconds != '0) begin
               step.time_next.seconds = now.seconds - 6'd1;
               step.time_next.millis = MILLI_MAX;
            end else if (now.minutes != '0) begin
               step.time_next.minutes = now.minutes - 6'd1;
               step.time_next.seconds = SECOND_MAX;
               step.time_next.millis = MILLI_MAX;
            end else if (now.hours != '0) begin
               step.time_next.hours = now.hours - 5'd1;
               step.time_next.minutes = MINUTE_MAX;
               step.time_next.seconds = SECOND_MAX;
               step.time_next.millis = MILLI_MAX;
            end else begin
               step.reached_zero = 1'b1;
            end
         end
         OP_CLEAR: begin
            step.time_next = '0;
         end
         OP_LOAD: begin
            step.time_next.hours = (ld_h > HOUR_MAX) ? HOUR_MAX : ld_h;
            step.time_next.minutes = (ld_m > MINUTE_MAX) ? MINUTE_MAX : ld_m;
            step.time_next.seconds = (ld_s > SECOND_MAX) ? SECOND_MAX : ld_s;
            step.time_next.millis = '0;
         end
      endcase
      return step;
   endfunction

   // Called right after a rising edge; returns right after the edge that took the item.
   task automatic send_item(input hms_op_type op, input logic [4:0] ld_h,
                            input logic [5:0] ld_m, input logic [5:0] ld_s,
                            input bit checked, input hms_step_type want);
      hms_step_type step;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_load_hours <= ld_h;
      req_load_minutes <= ld_m;
      req_load_seconds <= ld_s;
      do @(posedge clock); while (!req_ready);
      step = advance_time(count_now, op, ld_h, ld_m, ld_s);
      count_now = step.time_next;
      expected_steps.push_back(checked ? want : step);
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: unexpected result item %0d:%0d:%0d.%0d", $realtime,
                        rsp_hours, rsp_minutes, rsp_seconds, rsp_millis);
            end
         end else begin
            oldest_step = expected_steps.pop_front();
            if (rsp_hours !== oldest_step.time_next.hours
                || rsp_minutes !== oldest_step.time_next.minutes
                || rsp_seconds !== oldest_step.time_next.seconds
                || rsp_millis !== oldest_step.time_next.millis
                || rsp_day_rollover !== oldest_step.day_rollover
                || rsp_reached_zero !== oldest_step.reached_zero) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: expected %0d:%0d:%0d.%0d roll %0b zero %0b", $realtime,
                           oldest_step.time_next.hours, oldest_step.time_next.minutes,
                           oldest_step.time_next.seconds, oldest_step.time_next.millis,
                           oldest_step.day_rollover, oldest_step.reached_zero);
                  $display("%0t:   actual %0d:%0d:%0d.%0d roll %0b zero %0b", $realtime,
                           rsp_hours, rsp_minutes, rsp_seconds, rsp_millis,
                           rsp_day_rollover, rsp_reached_zero);
               end
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      hms_step_type     want;
      hms_op_type       op;
      logic [4:0]       ld_h;
      logic [5:0]       ld_m;
      logic [5:0]       ld_s;
      int               up_run_len;
      int               which;
      bit               bias_up;
      bit               rollover_done;

      up_run_len = 0;
      rollover_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         want = '0;
         want.time_next.hours = row.w_h;
         want.time_next.minutes = row.w_m;
         want.time_next.seconds = row.w_s;
         want.time_next.millis = row.w_ms;
         want.day_rollover = row.w_roll;
         want.reached_zero = row.w_zero;
         send_item(row.op, row.ld_h, row.ld_m, row.ld_s, row.checked, want);
      end

      while (items_sent < ITEM_TARGET) begin
         idle_on = (items_sent < ITEM_TARGET - 150) && ($urandom_range(0, 3) != 0);
         if (!rollover_done) begin
            // Only a full second of up ticks from 23:59:59.000 can wrap the day.
            up_run_len = 1001 + $urandom_range(0, 3);
            send_item(OP_LOAD, HOUR_MAX, MINUTE_MAX, SECOND_MAX, 1'b0, '0);
            repeat (up_run_len - 1) begin
               send_item(OP_UP, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
            end
            rollover_done = 1'b1;
         end else begin
            which = $urandom_range(0, 9);
            if (which <= 4) begin
               // Load a time, then a run of ticks leaning one way to cross digit borders.
               ld_h = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 23));
               ld_m = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 59));
               ld_s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 59));
               send_item(OP_LOAD, ld_h, ld_m, ld_s, 1'b0, '0);
               bias_up = 1'($urandom_range(0, 1));
               repeat ($urandom_range(4, 20)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     op = bias_up ? OP_DOWN : OP_UP;
                  end else begin
                     op = bias_up ? OP_UP : OP_DOWN;
                  end
                  send_item(op, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               end
            end else if (which == 5) begin
               send_item(OP_CLEAR, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               repeat ($urandom_range(1, 4)) begin
                  send_item(OP_DOWN, 5'($urandom()), 6'($urandom()), 6'($urandom()),
                            1'b0, '0);
               end
               repeat ($urandom_range(1, 6)) begin
                  op = $urandom_range(0, 1) ? OP_UP : OP_DOWN;
                  send_item(op, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               end
            end else if (which == 6) begin
               // One nonzero digit, so the first down tick borrows through all lower ones.
               ld_h = '0;
               ld_m = '0;
               ld_s = '0;
               case ($urandom_range(0, 2))
                  0: ld_h = 5'($urandom_range(1, 31));
                  1: ld_m = 6'($urandom_range(1, 63));
                  default: ld_s = 6'($urandom_range(1, 63));
               endcase
               send_item(OP_LOAD, ld_h, ld_m, ld_s, 1'b0, '0);
               send_item(OP_DOWN, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               send_item(OP_UP, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               send_item(OP_UP, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
               send_item(OP_DOWN, 5'($urandom()), 6'($urandom()), 6'($urandom()), 1'b0, '0);
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  send_item(hms_op_type'($urandom_range(0, 3)), 5'($urandom()),
                            6'($urandom()), 6'($urandom()), 1'b0, '0);
               end
            end
         end
      end

      req_valid <= 1'b0;
      idle_on = 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("hms_millisecond_up_down_counter_top regression: pass");
      end else begin
         $display("hms_millisecond_up_down_counter_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/hms_pkg.sv
rtl/core/hms_step.sv
rtl/core/hms_millisecond_up_down_counter_top.sv
tb/tb.sv
